/* rtl/mpid_pkg.sv */
// ----------------------------------------------------------------------------
// Multichannel PID controller package
// Request and result types, command codes and shared constants.
// ----------------------------------------------------------------------------
package mpid_pkg;

    // Default number of motor channels and fraction bits of the Q-format gains.
    localparam int MPID_CHANNELS       = 16;
    localparam int MPID_GAIN_FRAC_BITS = 8;

    // The integral is cleared while the error lies strictly inside this band.
    localparam int CLEAR_BAND = 5;
    // The drive value is clamped to this magnitude.
    localparam int DRIVE_MAX  = 127;

    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 16;
    localparam int DRIVE_W = 8;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_SET_TARGET,
        CMD_SET_GAINS,
        CMD_LINK
    } cmd_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic [CHAN_W-1:0]           channel;
        logic signed [VALUE_W-1:0]   encoder_value;
        logic signed [VALUE_W-1:0]   setpoint;
        logic signed [VALUE_W-1:0]   gain_p;
        logic signed [VALUE_W-1:0]   gain_i;
        logic signed [VALUE_W-1:0]   gain_d;
        logic                        reverse_sense;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0]           out_channel;
        logic signed [DRIVE_W-1:0]   drive;
    } rsp_t;

endpackage

/* rtl/multichannel_pid_controller_unit.sv */
// ----------------------------------------------------------------------------
// Multichannel PID controller unit
// Per-channel PID loops with Q-format gains, clamped signed drive output.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                    Handshake
//  --------  -----------------------  -------------------------------------
//  request   start, busy, request     taken at a clock edge with start high
//                                     and busy low
//  result    done, result             done marks a result for one cycle
//
// A request is taken in every cycle; busy stays low. A tick request on an
// active channel has its result on the ports once it has passed from the
// input register through the operand register (the state update), the
// product register (the three gain multipliers) and the result register
// (the sum, shift and clamp). Other requests give no result. The receiver
// cannot stall the result; done is a one-cycle strobe.
// Reset clears all per-channel state (targets, gains, integrals, last errors
// and link flags) at once and drops every request in flight.
//
module multichannel_pid_controller_unit #(
    parameter int CHANNELS       = mpid_pkg::MPID_CHANNELS,
    parameter int GAIN_FRAC_BITS = mpid_pkg::MPID_GAIN_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mpid_pkg::req_t   request,
    output logic             done,
    output mpid_pkg::rsp_t   result
);
    import mpid_pkg::*;

    // Index width of the per-channel state, and width of the product sum.
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int SUM_W  = PROD_W + 2;
    // Added to a negative sum before the arithmetic shift so that the
    // division by a power of two truncates toward zero.
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // Per-channel state, held in flip-flops.
    logic [VALUE_W-1:0] integral_reg [CHANNELS];
    logic [VALUE_W-1:0] last_err_reg [CHANNELS];
    logic [VALUE_W-1:0] target_reg   [CHANNELS];
    logic [VALUE_W-1:0] kp_reg       [CHANNELS];
    logic [VALUE_W-1:0] ki_reg       [CHANNELS];
    logic [VALUE_W-1:0] kd_reg       [CHANNELS];
    logic [CHANNELS-1:0] active_reg;
    logic [CHANNELS-1:0] reversed_reg;

    // Input register.
    logic        in_valid_reg;
    req_t        in_req_reg;

    // Operand register, loaded by the state update stage.
    logic                      op_valid_reg;
    logic [CHAN_W-1:0]         op_chan_reg;
    logic signed [VALUE_W-1:0] op_err_reg;
    logic signed [VALUE_W-1:0] op_integ_reg;
    logic signed [VALUE_W-1:0] op_deriv_reg;
    logic signed [VALUE_W-1:0] op_kp_reg;
    logic signed [VALUE_W-1:0] op_ki_reg;
    logic signed [VALUE_W-1:0] op_kd_reg;

    // Product register.
    logic                     prod_valid_reg;
    logic [CHAN_W-1:0]        prod_chan_reg;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_d_reg;

    // Result register.
    logic done_reg;
    rsp_t result_reg;

    // The request path never stalls.
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // State update stage: read the addressed channel, form the error
    // terms and decide which state words change.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   idx;
    logic               chan_ok;
    logic               tick_go;
    logic [VALUE_W-1:0] reading;
    logic [VALUE_W-1:0] err;
    logic [VALUE_W-1:0] integ_sum;
    logic [VALUE_W-1:0] integ_next;
    logic [VALUE_W-1:0] deriv;
    logic               in_band;

    always_comb
    begin
        idx     = IDX_W'(in_req_reg.channel);
        chan_ok = (int'(in_req_reg.channel) < CHANNELS);
        tick_go = in_valid_reg && chan_ok && (in_req_reg.cmd == CMD_TICK) && active_reg[idx];

        // A reversed channel negates its reading, wrapping at the most
        // negative value.
        reading = reversed_reg[idx] ? (VALUE_W'(0) - in_req_reg.encoder_value)
                                    : in_req_reg.encoder_value;
        err       = target_reg[idx] - reading;
        integ_sum = integral_reg[idx] + err;
        deriv     = err - last_err_reg[idx];

        // Small errors clear the integral so it does not wind up at rest.
        in_band = ($signed(err) > -VALUE_W'(CLEAR_BAND)) &&
                  ($signed(err) <  VALUE_W'(CLEAR_BAND));
        integ_next = in_band ? '0 : integ_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                integral_reg[i] <= '0;
                last_err_reg[i] <= '0;
                target_reg[i]   <= '0;
                kp_reg[i]       <= '0;
                ki_reg[i]       <= '0;
                kd_reg[i]       <= '0;
            end
            active_reg     <= '0;
            reversed_reg   <= '0;
            in_valid_reg   <= 1'b0;
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= start && !busy;
            op_valid_reg   <= tick_go;
            prod_valid_reg <= op_valid_reg;
            done_reg       <= prod_valid_reg;

            if (in_valid_reg && chan_ok)
            begin
                unique case (in_req_reg.cmd)
                    CMD_TICK:
                    begin
                        if (active_reg[idx])
                        begin
                            integral_reg[idx] <= integ_next;
                            last_err_reg[idx] <= err;
                        end
                    end
                    CMD_SET_TARGET:
                    begin
                        target_reg[idx] <= in_req_reg.setpoint;
                    end
                    CMD_SET_GAINS:
                    begin
                        kp_reg[idx] <= in_req_reg.gain_p;
                        ki_reg[idx] <= in_req_reg.gain_i;
                        kd_reg[idx] <= in_req_reg.gain_d;
                    end
                    CMD_LINK:
                    begin
                        active_reg[idx]   <= 1'b1;
                        reversed_reg[idx] <= in_req_reg.reverse_sense;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum, shift and clamp, and the payload registers of the pipeline; the registers need no reset.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] pid_sum;
    logic signed [SUM_W-1:0] pid_quot;
    logic signed [DRIVE_W-1:0] drive_next;

    always_comb
    begin
        pid_sum = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
        pid_quot = $signed(pid_sum + (pid_sum[SUM_W-1] ? ROUND_BIAS : '0)) >>> GAIN_FRAC_BITS;
        priority if (pid_quot > SUM_W'(DRIVE_MAX))
            drive_next = DRIVE_W'(DRIVE_MAX);
        else if (pid_quot < -SUM_W'(DRIVE_MAX))
            drive_next = -DRIVE_W'(DRIVE_MAX);
        else
            drive_next = DRIVE_W'(pid_quot);
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_req_reg <= request;

        op_chan_reg  <= in_req_reg.channel;
        op_err_reg   <= err;
        op_integ_reg <= integ_next;
        op_deriv_reg <= deriv;
        op_kp_reg    <= kp_reg[idx];
        op_ki_reg    <= ki_reg[idx];
        op_kd_reg    <= kd_reg[idx];

        prod_chan_reg <= op_chan_reg;
        prod_p_reg    <= op_err_reg   * op_kp_reg;
        prod_i_reg    <= op_integ_reg * op_ki_reg;
        prod_d_reg    <= op_deriv_reg * op_kd_reg;

        result_reg.out_channel <= prod_chan_reg;
        result_reg.drive       <= drive_next;
    end

endmodule

/* rtl/mpid_checker.sv */
// ----------------------------------------------------------------------------
// Multichannel PID controller checker
// Port-level checks on result timing and range, bound to the top level.
// ----------------------------------------------------------------------------
module mpid_checker #(
    parameter int CHANNELS = mpid_pkg::MPID_CHANNELS
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input mpid_pkg::req_t request,
    input logic           done,
    input mpid_pkg::rsp_t result
);
    import mpid_pkg::*;

    // Every result comes from a tick request on the same channel that was
    // taken earlier and passed the operand, product and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy, 4) && ($past(request.cmd, 4) == CMD_TICK) &&
                  ($past(request.channel, 4) == result.out_channel)))
        else $error("result without a matching tick request");

    // The drive never reaches the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.drive != 8'sh80))
        else $error("drive outside the clamp range");

    // Results only name channels that exist.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(result.out_channel) < CHANNELS))
        else $error("result for a channel beyond the configured count");

    // Reset leaves no result pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result strobe right after reset");

endmodule

bind multichannel_pid_controller_unit mpid_checker #(
    .CHANNELS (CHANNELS)
) u_mpid_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
